// ===== rtl/lts_pkg.sv =====
// Package for the token scanner: widths, byte codes, result codes,
// result and bundle structs, and small helpers for classifying bytes.
// No dependencies.
package lts_pkg;

    localparam int POS_BITS    = 16;
    localparam int OFFSET_BITS = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [POS_BITS-1:0]    POS_MAX = {POS_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [POS_BITS-1:0]    POS_ONE = {{(POS_BITS-1){1'b0}}, 1'b1};

    // byte codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // result kinds
    localparam logic [1:0] RK_TOKEN     = 2'd0;
    localparam logic [1:0] RK_UNTERM    = 2'd1;
    localparam logic [1:0] RK_BACKSLASH = 2'd2;

    // token kinds
    localparam logic [1:0] TK_NUMBER   = 2'd0;
    localparam logic [1:0] TK_STRING   = 2'd1;
    localparam logic [1:0] TK_SYMBOL   = 2'd2;
    localparam logic [1:0] TK_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]             result_kind;
        logic [1:0]             token_kind;
        logic [POS_BITS-1:0]    line_number;
        logic [POS_BITS-1:0]    column_number;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [OFFSET_BITS-1:0] token_length;
    } result_t;

    // everything one byte produces: one or two results
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } bundle_t;

    function automatic logic [POS_BITS-1:0] sat_pos(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? POS_MAX : v + POS_ONE;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] v);
        return (v == OFF_MAX) ? OFF_MAX : v + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return (c inside {[CH_ZERO:CH_NINE], CH_DOT});
    endfunction

    function automatic logic is_res(input logic [7:0] c);
        return (c inside {CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN});
    endfunction

    function automatic logic is_sym(input logic [7:0] c);
        return !(c inside {CH_NUL, CH_QUOTE, CH_SEMI, CH_SPACE, CH_TAB, CH_LF, CH_BSLASH})
               && !is_num(c) && !is_res(c);
    endfunction

endpackage

// ===== rtl/lts_front.sv =====
// Front end of the token scanner: mode machine, position counters and
// result bundle for each accepted byte. Depends on lts_pkg.
module lts_front
    import lts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] char_byte,
    output logic       push,
    output bundle_t    bundle
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_SYMBOL,
        MODE_STRING,
        MODE_COMMENT,
        MODE_ERROR
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic                   pb_reg, pb_next;
    logic [POS_BITS-1:0]    row_reg, row_next;
    logic [POS_BITS-1:0]    col_reg, col_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [OFFSET_BITS-1:0] tso_reg, tso_next;
    logic [POS_BITS-1:0]    tsc_reg, tsc_next;

    logic    fall;
    logic    a_vld, b_vld;
    result_t a_res, b_res;
    logic [OFFSET_BITS-1:0] tok_len;

    assign tok_len = off_reg - tso_reg;

    always_comb begin
        mode_next = mode_reg;
        pb_next   = pb_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        off_next  = off_reg;
        tso_next  = tso_reg;
        tsc_next  = tsc_reg;
        fall      = 1'b0;
        a_vld     = 1'b0;
        b_vld     = 1'b0;
        a_res     = '{RK_TOKEN, TK_NUMBER, row_reg, tsc_reg, tso_reg, tok_len};
        b_res     = '{RK_TOKEN, TK_RESERVED, row_reg, col_reg, off_reg,
                      {{(OFFSET_BITS-1){1'b0}}, 1'b1}};

        case (mode_reg)
            MODE_NUMBER: begin
                if (is_num(char_byte)) begin
                    col_next = sat_pos(col_reg);
                    off_next = sat_off(off_reg);
                end else begin
                    a_vld     = 1'b1;
                    mode_next = MODE_IDLE;
                    fall      = 1'b1;
                end
            end
            MODE_SYMBOL: begin
                if (is_sym(char_byte)) begin
                    col_next = sat_pos(col_reg);
                    off_next = sat_off(off_reg);
                end else begin
                    a_vld            = 1'b1;
                    a_res.token_kind = TK_SYMBOL;
                    mode_next        = MODE_IDLE;
                    fall             = 1'b1;
                end
            end
            MODE_STRING: begin
                if (char_byte == CH_NUL) begin
                    a_vld = 1'b1;
                    a_res = '{RK_UNTERM, TK_NUMBER, row_reg, col_reg, off_reg, '0};
                    mode_next = MODE_IDLE;
                    pb_next   = 1'b0;
                    row_next  = POS_ONE;
                    col_next  = POS_ONE;
                    off_next  = '0;
                    tso_next  = '0;
                    tsc_next  = POS_ONE;
                end else if (char_byte == CH_QUOTE && !pb_reg) begin
                    a_vld            = 1'b1;
                    a_res.token_kind = TK_STRING;
                    mode_next        = MODE_IDLE;
                    pb_next          = 1'b0;
                    col_next         = sat_pos(col_reg);
                    off_next         = sat_off(off_reg);
                end else begin
                    // a newline here moves the column and offset on, not the row
                    pb_next  = (char_byte == CH_BSLASH);
                    col_next = sat_pos(col_reg);
                    off_next = sat_off(off_reg);
                end
            end
            MODE_COMMENT: begin
                if (char_byte != CH_NUL && char_byte != CH_LF) begin
                    col_next = sat_pos(col_reg);
                    off_next = sat_off(off_reg);
                end else begin
                    mode_next = MODE_IDLE;
                    fall      = 1'b1;
                end
            end
            MODE_ERROR: begin
                if (char_byte == CH_NUL) begin
                    mode_next = MODE_IDLE;
                    pb_next   = 1'b0;
                    row_next  = POS_ONE;
                    col_next  = POS_ONE;
                    off_next  = '0;
                    tso_next  = '0;
                    tsc_next  = POS_ONE;
                end else begin
                    col_next = sat_pos(col_reg);
                    off_next = sat_off(off_reg);
                end
            end
            default: begin
                mode_next = MODE_IDLE;
                fall      = 1'b1;
            end
        endcase

        // byte handled from idle, also after a number, symbol or comment has ended on it
        if (fall) begin
            if (char_byte == CH_NUL) begin
                mode_next = MODE_IDLE;
                pb_next   = 1'b0;
                row_next  = POS_ONE;
                col_next  = POS_ONE;
                off_next  = '0;
                tso_next  = '0;
                tsc_next  = POS_ONE;
            end else if (char_byte == CH_SPACE || char_byte == CH_TAB) begin
                col_next = sat_pos(col_reg);
                off_next = sat_off(off_reg);
            end else if (char_byte == CH_LF) begin
                row_next = sat_pos(row_reg);
                col_next = POS_ONE;
                off_next = sat_off(off_reg);
            end else if (char_byte == CH_SEMI) begin
                mode_next = MODE_COMMENT;
                col_next  = sat_pos(col_reg);
                off_next  = sat_off(off_reg);
            end else if (is_num(char_byte)) begin
                tso_next  = off_reg;
                tsc_next  = col_reg;
                mode_next = MODE_NUMBER;
                col_next  = sat_pos(col_reg);
                off_next  = sat_off(off_reg);
            end else if (char_byte == CH_QUOTE) begin
                // string position starts after the opening quote
                pb_next   = 1'b0;
                tso_next  = sat_off(off_reg);
                tsc_next  = sat_pos(col_reg);
                mode_next = MODE_STRING;
                col_next  = sat_pos(col_reg);
                off_next  = sat_off(off_reg);
            end else if (is_res(char_byte)) begin
                b_vld    = 1'b1;
                col_next = sat_pos(col_reg);
                off_next = sat_off(off_reg);
            end else if (char_byte == CH_BSLASH) begin
                b_vld = 1'b1;
                b_res = '{RK_BACKSLASH, TK_NUMBER, row_reg, col_reg, off_reg, '0};
                mode_next = MODE_ERROR;
                col_next  = sat_pos(col_reg);
                off_next  = sat_off(off_reg);
            end else begin
                tso_next  = off_reg;
                tsc_next  = col_reg;
                mode_next = MODE_SYMBOL;
                col_next  = sat_pos(col_reg);
                off_next  = sat_off(off_reg);
            end
        end
    end

    assign push          = accept && (a_vld || b_vld);
    assign bundle.two    = a_vld && b_vld;
    assign bundle.first  = a_vld ? a_res : b_res;
    assign bundle.second = b_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            pb_reg   <= 1'b0;
            row_reg  <= POS_ONE;
            col_reg  <= POS_ONE;
            off_reg  <= '0;
            tso_reg  <= '0;
            tsc_reg  <= POS_ONE;
        end else if (accept) begin
            mode_reg <= mode_next;
            pb_reg   <= pb_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            off_reg  <= off_next;
            tso_reg  <= tso_next;
            tsc_reg  <= tsc_next;
        end
    end

endmodule

// ===== rtl/lts_queue.sv =====
// Short bundle queue between scanner front end and output stage.
// Depends on lts_pkg.
module lts_queue
    import lts_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output logic    not_full,
    output logic    not_empty,
    output bundle_t pop_data
);

    bundle_t               mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wptr_reg, rptr_reg;
    logic [QPTR_BITS:0]    count_reg, count_next;

    localparam logic [QPTR_BITS:0] COUNT_FULL = QUEUE_DEPTH[QPTR_BITS:0];

    assign not_full  = (count_reg != COUNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (!push && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/lts_back.sv =====
// Output stage: takes bundles from the queue and sends their results one
// word at a time through a registered output. Depends on lts_pkg.
module lts_back
    import lts_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_not_empty,
    input  bundle_t q_data,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res,
    output logic    out_last
);

    logic    ovld_reg;
    result_t ores_reg;
    logic    olast_reg;
    logic    pvld_reg;      // second result of a bundle still to go
    result_t pres_reg;
    logic    load;

    assign load  = !ovld_reg || out_ready;
    assign q_pop = load && !pvld_reg && q_not_empty;

    assign out_valid = ovld_reg;
    assign out_res   = ores_reg;
    assign out_last  = olast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovld_reg <= 1'b0;
            pvld_reg <= 1'b0;
        end else if (load) begin
            if (pvld_reg) begin
                ovld_reg <= 1'b1;
                pvld_reg <= 1'b0;
            end else if (q_not_empty) begin
                ovld_reg <= 1'b1;
                pvld_reg <= q_data.two;
            end else begin
                ovld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (pvld_reg) begin
                ores_reg  <= pres_reg;
                olast_reg <= 1'b1;
            end else if (q_not_empty) begin
                ores_reg  <= q_data.first;
                olast_reg <= !q_data.two;
                pres_reg  <= q_data.second;
            end
        end
    end

endmodule

// ===== rtl/lisp_token_scanner_unit.sv =====
// Top level of the s-expression token scanner: front end, bundle queue,
// output stage. Depends on lts_pkg, lts_front, lts_queue, lts_back.
//
//  channel | ports                              | carries
//  --------+------------------------------------+------------------------------
//  input   | s_valid, s_ready, s_char_byte      | one source byte per word
//  result  | m_valid, m_ready, m_result_kind .. | one token or error per word
//
// A byte is taken every cycle while the four-entry bundle queue has room; its
// state update is done in the cycle it is accepted. A byte yields zero, one or
// two results; unless m_ready stalls it, the output stage sends one result a
// cycle from a register, so a two-result byte gives two words. Results pass the
// queue and output register. Reset is synchronous and clears mode, counters,
// queue and output valid. A stalled output fills the queue, then s_ready drops.
module lisp_token_scanner_unit
    import lts_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_char_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_result_kind,
    output logic [1:0]             m_token_kind,
    output logic [POS_BITS-1:0]    m_line_number,
    output logic [POS_BITS-1:0]    m_column_number,
    output logic [OFFSET_BITS-1:0] m_start_offset,
    output logic [OFFSET_BITS-1:0] m_token_length,
    output logic                   m_last_of_run
);

    logic    accept;
    logic    push, pop, q_not_full, q_not_empty;
    bundle_t push_data, pop_data;
    result_t out_res;

    assign s_ready = q_not_full;
    assign accept  = s_valid && q_not_full;

    lts_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .char_byte (s_char_byte),
        .push      (push),
        .bundle    (push_data)
    );

    lts_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .not_full  (q_not_full),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    lts_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (pop_data),
        .q_pop       (pop),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_res     (out_res),
        .out_last    (m_last_of_run)
    );

    assign m_result_kind   = out_res.result_kind;
    assign m_token_kind    = out_res.token_kind;
    assign m_line_number   = out_res.line_number;
    assign m_column_number = out_res.column_number;
    assign m_start_offset  = out_res.start_offset;
    assign m_token_length  = out_res.token_length;

endmodule
